/* rtl/pbx_pkg.sv */
// package for the parabola breakpoint core: status codes and default widths
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package pbx_pkg;

  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int STATUS_WIDTH        = 3;

  typedef logic [STATUS_WIDTH-1:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_ON_SWEEP = 3'd1;
  localparam status_t ST_EQUAL    = 3'd2;
  localparam status_t ST_NEG_DISC = 3'd3;
  localparam status_t ST_SAT      = 3'd4;

endpackage

/* rtl/parabola_breakpoint_x_core.sv */
// top level: breakpoint x of two beachline parabolas, fully pipelined
// depends on pbx_pkg, pbx_sqrt_pipe and pbx_div_pipe
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   input    | start, busy      | left_site_x/y, right_site_x/y, sweep_y
//   result   | done (strobe)    | breakpoint_x, status
//
// one transaction per cycle; busy is always low.
// the path runs through the square root pipe (2*COORD_WIDTH+2 stages), the
// divider pipe (2*COORD_WIDTH+3 stages) and eight arithmetic stages.
// rst clears only the valid bits; payload registers are not reset.
// the result side cannot stall; each result shows on done for one cycle.
`timescale 1ns / 1ps

module parabola_breakpoint_x_core #(
  parameter int COORD_WIDTH = pbx_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] left_site_x,
  input  logic signed [COORD_WIDTH-1:0] left_site_y,
  input  logic signed [COORD_WIDTH-1:0] right_site_x,
  input  logic signed [COORD_WIDTH-1:0] right_site_y,
  input  logic signed [COORD_WIDTH-1:0] sweep_y,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] breakpoint_x,
  output pbx_pkg::status_t              status
);

  import pbx_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int SW    = W + 1;
  localparam int PrW   = 2 * W + 2;
  localparam int PW    = 2 * W + 1;
  localparam int H     = W + 1;
  localparam int HiW   = PW - H;
  localparam int RootW = PW;
  localparam int RadW  = 2 * PW;
  localparam int BW    = 2 * W + 2;
  localparam int NW    = 2 * W + 2;
  localparam int QrW   = NW + 1;
  localparam int Lat   = 10 + RootW + NW;

  localparam logic [QrW-1:0] QLim = QrW'(1) << (W - 1);
  localparam logic [W-1:0]   XMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   XMin = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic          special;
    logic [W-1:0]  x;
    status_t       st;
  } spec_t;

  typedef struct packed {
    spec_t         spec;
    logic [BW-1:0] b;
    logic          a_neg;
    logic [W-1:0]  a_mag;
  } sq_side_t;

  typedef struct packed {
    spec_t         spec;
    logic          q_neg;
    logic [W-1:0]  a_mag;
  } dv_side_t;

  assign busy = 1'b0;

  // stage 1: differences and early-out cases
  logic signed [SW-1:0] a1_c, a2_c, ad_c, dx_c;
  spec_t spec_c;

  assign a1_c = SW'(left_site_y) - SW'(sweep_y);
  assign a2_c = SW'(right_site_y) - SW'(sweep_y);
  assign ad_c = SW'(right_site_y) - SW'(left_site_y);
  assign dx_c = SW'(left_site_x) - SW'(right_site_x);

  always_comb begin
    spec_c.special = 1'b1;
    spec_c.x       = '0;
    spec_c.st      = ST_OK;
    if (a1_c == '0) begin
      spec_c.x  = left_site_x;
      spec_c.st = ST_ON_SWEEP;
    end else if (a2_c == '0) begin
      spec_c.x  = right_site_x;
      spec_c.st = ST_ON_SWEEP;
    end else if (ad_c == '0) begin
      spec_c.st = ST_EQUAL;
    end else if (a1_c[SW-1] != a2_c[SW-1]) begin
      // discriminant is a1*a2*(dx^2 + A^2), negative exactly here
      spec_c.st = ST_NEG_DISC;
    end else begin
      spec_c.special = 1'b0;
    end
  end

  logic s1_v, s2_v, s3_v, s4_v, s5_v, s7_v, s8_v;

  logic signed [SW-1:0] s1_a1, s1_a2, s1_ad, s1_dx;
  logic signed [W-1:0]  s1_x1, s1_x2;
  spec_t                s1_spec;

  logic signed [PrW-1:0] s2_p, s2_dx2, s2_asq;
  logic signed [BW-1:0]  s2_m1, s2_m2;
  logic signed [SW-1:0]  s2_ad;
  spec_t                 s2_spec;

  logic [PW-1:0]         s3_pm, s3_q;
  sq_side_t              s3_side;
  logic signed [SW-1:0]  ad_abs_c;

  logic [2*H-1:0]        s4_ll;
  logic [H+HiW-1:0]      s4_lh, s4_hl;
  logic [2*HiW-1:0]      s4_hh;
  sq_side_t              s4_side;

  logic [H+HiW:0]        s5_mid;
  logic [2*H-1:0]        s5_ll;
  logic [2*HiW-1:0]      s5_hh;
  sq_side_t              s5_side;
  logic [RadW-1:0]       d_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      s1_v <= start && !busy;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  assign ad_abs_c = s2_ad[SW-1] ? -s2_ad : s2_ad;

  always_ff @(posedge clk) begin
    // stage 1
    s1_a1   <= a1_c;
    s1_a2   <= a2_c;
    s1_ad   <= ad_c;
    s1_dx   <= dx_c;
    s1_x1   <= left_site_x;
    s1_x2   <= right_site_x;
    s1_spec <= spec_c;
    // stage 2: products
    s2_p    <= PrW'(s1_a1) * PrW'(s1_a2);
    s2_dx2  <= PrW'(s1_dx) * PrW'(s1_dx);
    s2_asq  <= PrW'(s1_ad) * PrW'(s1_ad);
    s2_m1   <= BW'(s1_a1) * BW'(s1_x2);
    s2_m2   <= BW'(s1_a2) * BW'(s1_x1);
    s2_ad   <= s1_ad;
    s2_spec <= s1_spec;
    // stage 3: D = P * Q with P = a1*a2 and Q = dx^2 + A^2
    s3_pm         <= s2_p[PW-1:0];
    s3_q          <= s2_dx2[PW-1:0] + s2_asq[PW-1:0];
    s3_side.spec  <= s2_spec;
    s3_side.b     <= s2_m1 - s2_m2;
    s3_side.a_neg <= s2_ad[SW-1];
    s3_side.a_mag <= ad_abs_c[W-1:0];
    // stage 4: partial products of P * Q
    s4_ll   <= (2*H)'(s3_pm[H-1:0]) * (2*H)'(s3_q[H-1:0]);
    s4_lh   <= (H+HiW)'(s3_pm[H-1:0]) * (H+HiW)'(s3_q[PW-1:H]);
    s4_hl   <= (H+HiW)'(s3_pm[PW-1:H]) * (H+HiW)'(s3_q[H-1:0]);
    s4_hh   <= (2*HiW)'(s3_pm[PW-1:H]) * (2*HiW)'(s3_q[PW-1:H]);
    s4_side <= s3_side;
    // stage 5: cross terms
    s5_mid  <= (H+HiW+1)'(s4_lh) + (H+HiW+1)'(s4_hl);
    s5_ll   <= s4_ll;
    s5_hh   <= s4_hh;
    s5_side <= s4_side;
  end

  assign d_c = {s5_hh, s5_ll} + (RadW'(s5_mid) << H);

  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  sq_side_t         sq_side;

  pbx_sqrt_pipe #(
    .ROOT_WIDTH (RootW),
    .SIDE_WIDTH ($bits(sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_v),
    .radicand  (d_c),
    .in_side   (s5_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // stage 7: numerator sqrt(D) - B, split into sign and magnitude
  logic signed [BW:0] n_c, n_abs_c;
  logic [NW-1:0]      s7_num;
  dv_side_t           s7_side;

  assign n_c     = $signed((BW+1)'(sq_root)) - (BW+1)'($signed(sq_side.b));
  assign n_abs_c = n_c[BW] ? -n_c : n_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else begin
      s7_v <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    s7_num        <= n_abs_c[NW-1:0];
    s7_side.spec  <= sq_side.spec;
    s7_side.q_neg <= n_c[BW] ^ sq_side.a_neg;
    s7_side.a_mag <= sq_side.a_mag;
  end

  logic          dv_valid;
  logic [NW-1:0] dv_quot;
  logic [W-1:0]  dv_rem;
  dv_side_t      dv_side;

  pbx_div_pipe #(
    .NUM_WIDTH  (NW),
    .DEN_WIDTH  (W),
    .SIDE_WIDTH ($bits(dv_side_t))
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s7_v),
    .numerator   (s7_num),
    .denominator (s7_side.a_mag),
    .in_side     (s7_side),
    .out_valid   (dv_valid),
    .quotient    (dv_quot),
    .remainder   (dv_rem),
    .out_side    (dv_side)
  );

  // stage 8: round half away from zero on the magnitude
  logic           rnd_c;
  logic [QrW-1:0] s8_qr;
  dv_side_t       s8_side;

  assign rnd_c = ({dv_rem, 1'b0} >= {1'b0, dv_side.a_mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else begin
      s8_v <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    s8_qr   <= QrW'(dv_quot) + QrW'(rnd_c);
    s8_side <= dv_side;
  end

  // stage 9: sign, saturation and early-out selection
  logic [W-1:0] x_next;
  status_t      st_next;

  always_comb begin
    x_next  = s8_qr[W-1:0];
    st_next = ST_OK;
    if (s8_side.spec.special) begin
      x_next  = s8_side.spec.x;
      st_next = s8_side.spec.st;
    end else if (!s8_side.q_neg) begin
      if (s8_qr >= QLim) begin
        x_next  = XMax;
        st_next = ST_SAT;
      end
    end else begin
      if (s8_qr > QLim) begin
        x_next  = XMin;
        st_next = ST_SAT;
      end else begin
        x_next = -s8_qr[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    breakpoint_x <= x_next;
    status       <= st_next;
  end

  a_latency_fwd : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Lat done)
    else $error("accepted transaction produced no result");

  a_latency_back : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Lat))
    else $error("result without a matching transaction");

  a_zero_codes : assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EQUAL || status == ST_NEG_DISC)) |-> (breakpoint_x == '0))
    else $error("degenerate status with nonzero x");

  a_sat_value : assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SAT) |-> (breakpoint_x == XMax || breakpoint_x == XMin))
    else $error("saturated status without a range end");

endmodule

/* rtl/pbx_sqrt_pipe.sv */
// pipelined integer square root, one root bit per register stage
// standalone; a sideband vector rides along with each operand
`timescale 1ns / 1ps

module pbx_sqrt_pipe #(
  parameter int ROOT_WIDTH = 65,
  parameter int SIDE_WIDTH = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [2*ROOT_WIDTH-1:0] radicand,
  input  logic [SIDE_WIDTH-1:0]   in_side,
  output logic                    out_valid,
  output logic [ROOT_WIDTH-1:0]   root,
  output logic [SIDE_WIDTH-1:0]   out_side
);

  localparam int RadW = 2 * ROOT_WIDTH;
  localparam int RemW = ROOT_WIDTH + 2;

  logic [ROOT_WIDTH:0] vld;
  logic [RadW-1:0]       rad_q  [ROOT_WIDTH+1];
  logic [RemW-1:0]       rem_q  [ROOT_WIDTH+1];
  logic [ROOT_WIDTH-1:0] root_q [ROOT_WIDTH+1];
  logic [SIDE_WIDTH-1:0] side_q [ROOT_WIDTH+1];

  logic [RemW+1:0] sh    [ROOT_WIDTH];
  logic [RemW+1:0] trial [ROOT_WIDTH];
  logic [RemW+1:0] diff  [ROOT_WIDTH];
  logic [RemW+1:0] nrem  [ROOT_WIDTH];
  logic            ge    [ROOT_WIDTH];

  // each stage brings down two radicand bits and tries the next root bit
  always_comb begin
    for (int i = 0; i < ROOT_WIDTH; i++) begin
      sh[i]    = {rem_q[i], rad_q[i][RadW-1 -: 2]};
      trial[i] = {2'b00, root_q[i], 2'b01};
      ge[i]    = (sh[i] >= trial[i]);
      diff[i]  = sh[i] - trial[i];
      nrem[i]  = ge[i] ? diff[i] : sh[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ROOT_WIDTH-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rad_q[0]  <= radicand;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    side_q[0] <= in_side;
    for (int i = 0; i < ROOT_WIDTH; i++) begin
      rad_q[i+1]  <= rad_q[i] << 2;
      rem_q[i+1]  <= nrem[i][RemW-1:0];
      root_q[i+1] <= {root_q[i][ROOT_WIDTH-2:0], ge[i]};
      side_q[i+1] <= side_q[i];
    end
  end

  assign out_valid = vld[ROOT_WIDTH];
  assign root      = root_q[ROOT_WIDTH];
  assign out_side  = side_q[ROOT_WIDTH];

endmodule

/* rtl/pbx_div_pipe.sv */
// pipelined restoring divider, one quotient bit per register stage
// standalone; unsigned operands, sideband vector rides along
`timescale 1ns / 1ps

module pbx_div_pipe #(
  parameter int NUM_WIDTH  = 66,
  parameter int DEN_WIDTH  = 32,
  parameter int SIDE_WIDTH = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [NUM_WIDTH-1:0]  numerator,
  input  logic [DEN_WIDTH-1:0]  denominator,
  input  logic [SIDE_WIDTH-1:0] in_side,
  output logic                  out_valid,
  output logic [NUM_WIDTH-1:0]  quotient,
  output logic [DEN_WIDTH-1:0]  remainder,
  output logic [SIDE_WIDTH-1:0] out_side
);

  logic [NUM_WIDTH:0] vld;
  logic [NUM_WIDTH-1:0]  num_q  [NUM_WIDTH+1];
  logic [DEN_WIDTH-1:0]  den_q  [NUM_WIDTH+1];
  logic [DEN_WIDTH-1:0]  rem_q  [NUM_WIDTH+1];
  logic [SIDE_WIDTH-1:0] side_q [NUM_WIDTH+1];

  logic [DEN_WIDTH:0] sh   [NUM_WIDTH];
  logic [DEN_WIDTH:0] diff [NUM_WIDTH];
  logic [DEN_WIDTH:0] nrem [NUM_WIDTH];
  logic               ge   [NUM_WIDTH];

  always_comb begin
    for (int i = 0; i < NUM_WIDTH; i++) begin
      sh[i]   = {rem_q[i], num_q[i][NUM_WIDTH-1]};
      ge[i]   = (sh[i] >= {1'b0, den_q[i]});
      diff[i] = sh[i] - {1'b0, den_q[i]};
      nrem[i] = ge[i] ? diff[i] : sh[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NUM_WIDTH-1:0], in_valid};
    end
  end

  // numerator bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    num_q[0]  <= numerator;
    den_q[0]  <= denominator;
    rem_q[0]  <= '0;
    side_q[0] <= in_side;
    for (int i = 0; i < NUM_WIDTH; i++) begin
      num_q[i+1]  <= {num_q[i][NUM_WIDTH-2:0], ge[i]};
      den_q[i+1]  <= den_q[i];
      rem_q[i+1]  <= nrem[i][DEN_WIDTH-1:0];
      side_q[i+1] <= side_q[i];
    end
  end

  assign out_valid = vld[NUM_WIDTH];
  assign quotient  = num_q[NUM_WIDTH];
  assign remainder = rem_q[NUM_WIDTH];
  assign out_side  = side_q[NUM_WIDTH];

endmodule

/* verif/tb.sv */
// testbench for parabola_breakpoint_x_core: directed table, then random site queries
// depends on pbx_pkg and the rtl; results are checked against an exact wide-integer predictor
`timescale 1ns / 1ps

module tb;
  import pbx_pkg::*;

  localparam int CW = 32;
  localparam int LATENCY = 4 * CW + 15;
  localparam int N_RANDOM = 2000;
  localparam int QUIET_TAIL = 200;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [199:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x1, y1, x2, y2, s;
    bit known;
    coord_t bx;
    status_t st;
  } query_t;

  typedef struct {
    coord_t bx;
    status_t st;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  coord_t left_site_x = '0, left_site_y = '0, right_site_x = '0, right_site_y = '0;
  coord_t sweep_y = '0;
  logic done;
  coord_t breakpoint_x;
  status_t status;

  answer_t pending_answers[$];
  query_t directed[$];
  int n_errors = 0;
  int n_checked = 0;
  int st_seen[5] = '{default: 0};
  longint cycles = 0;

  always #2 clk = ~clk;

  parabola_breakpoint_x_core #(.COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .left_site_x(left_site_x), .left_site_y(left_site_y),
    .right_site_x(right_site_x), .right_site_y(right_site_y), .sweep_y(sweep_y),
    .done(done), .breakpoint_x(breakpoint_x), .status(status)
  );

  function automatic wide_t isqrt_floor(wide_t d);
    wide_t r, c;
    r = '0;
    for (int i = 70; i >= 0; i--) begin
      c = r | (wide_t'(1) <<< i);
      if (c * c <= d) r = c;
    end
    return r;
  endfunction

  function automatic answer_t breakpoint_of(coord_t x1i, coord_t y1i, coord_t x2i,
                                            coord_t y2i, coord_t si);
    wide_t x1, y1, x2, y2, s, a1, a2, ca, cb, cc, disc, num, nm, am, q, rm, half;
    answer_t r;
    x1 = x1i; y1 = y1i; x2 = x2i; y2 = y2i; s = si;
    a1 = y1 - s;
    a2 = y2 - s;
    half = wide_t'(1) <<< (CW - 1);
    if (a1 == 0) return '{x1i, ST_ON_SWEEP};
    if (a2 == 0) return '{x2i, ST_ON_SWEEP};
    ca = y2 - y1;
    if (ca == 0) return '{'0, ST_EQUAL};
    cb = a1 * x2 - a2 * x1;
    cc = a2 * x1 * x1 - a1 * x2 * x2 + a1 * a2 * (a1 - a2);
    disc = cb * cb - ca * cc;
    if (disc < 0) return '{'0, ST_NEG_DISC};
    num = isqrt_floor(disc) - cb;
    nm = (num < 0) ? -num : num;
    am = (ca < 0) ? -ca : ca;
    q = nm / am;
    rm = nm % am;
    // round half away from zero
    if (rm >= am - rm) q = q + 1;
    if ((num < 0) != (ca < 0)) q = -q;
    if (q >= half) return '{{1'b0, {(CW-1){1'b1}}}, ST_SAT};
    if (q < -half) return '{{1'b1, {(CW-1){1'b0}}}, ST_SAT};
    r.bx = q[CW-1:0];
    r.st = ST_OK;
    return r;
  endfunction

  // scoreboard: record every accepted transaction, check every strobe
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        pending_answers.push_back(breakpoint_of(left_site_x, left_site_y, right_site_x,
                                                right_site_y, sweep_y));
      if (done) begin
        if (pending_answers.size() == 0) begin
          $error("result with nothing expected: breakpoint_x %0d status %0d",
                 breakpoint_x, status);
          n_errors++;
        end else begin
          answer_t e;
          e = pending_answers.pop_front();
          n_checked++;
          if (status <= ST_SAT) st_seen[status]++;
          if (breakpoint_x !== e.bx) begin
            $error("breakpoint_x expected %0d actual %0d", e.bx, breakpoint_x);
            n_errors++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(query_t t, bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    left_site_x <= t.x1; left_site_y <= t.y1;
    right_site_x <= t.x2; right_site_y <= t.y2;
    sweep_y <= t.s;
    start <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  function automatic query_t row(coord_t x1, coord_t y1, coord_t x2, coord_t y2, coord_t s,
                                 bit known = 0, coord_t bx = '0, status_t st = ST_OK);
    query_t t;
    t = '{x1, y1, x2, y2, s, known, bx, st};
    return t;
  endfunction

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h0000_0fff)) - 32'sh0000_0800;
    endcase
  endfunction

  initial begin
    query_t t;
    answer_t a;
    coord_t cmax, cmin;
    int mode;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};

    // left or right site on the sweep line
    directed.push_back(row(32'sh0001_0000, 5, 7, 9, 5, 1, 32'sh0001_0000, ST_ON_SWEEP));
    directed.push_back(row(3, 9, cmin, 5, 5, 1, cmin, ST_ON_SWEEP));
    directed.push_back(row(cmax, cmax, cmin, cmin, cmax, 1, cmax, ST_ON_SWEEP));
    directed.push_back(row(1, 0, 2, 0, 0, 1, 1, ST_ON_SWEEP));
    // equal heights
    directed.push_back(row(0, 100, 50, 100, 0, 1, 0, ST_EQUAL));
    directed.push_back(row(cmin, cmax, cmax, cmax, cmin, 1, 0, ST_EQUAL));
    // sites on opposite sides of the sweep line do not meet
    directed.push_back(row(0, 1, 0, -1, 0, 1, 0, ST_NEG_DISC));
    // ordinary queries, both orderings of heights
    directed.push_back(row(0, 32'sh0002_0000, 32'sh0004_0000, 32'sh0001_0000, 0));
    directed.push_back(row(0, 32'sh0001_0000, 32'sh0004_0000, 32'sh0002_0000, 0));
    directed.push_back(row(-32'sh0003_0000, 32'sh0005_0000, 32'sh0003_0000, 32'sh0006_0000,
                           32'sh0001_0000));
    directed.push_back(row(-5, -3, 8, -9, -20));
    // extremes, likely to saturate
    directed.push_back(row(cmax, cmax, cmin, cmax - 1, cmin));
    directed.push_back(row(cmin, cmin + 1, cmax, cmin + 2, cmin));
    directed.push_back(row(cmax, cmin, cmin, cmax, 0));
    directed.push_back(row(cmin, 1, cmax, 2, 0));
    directed.push_back(row(cmax, 2, cmin, 1, 0));
    directed.push_back(row(0, cmax, 0, cmin, -1));
    directed.push_back(row(-1, -1, -1, -2, cmax));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].known) begin
        a = breakpoint_of(directed[i].x1, directed[i].y1, directed[i].x2, directed[i].y2,
                          directed[i].s);
        if (a.bx !== directed[i].bx || a.st !== directed[i].st) begin
          $error("table row %0d: breakpoint_x expected %0d status %0d, predicted %0d %0d",
                 i, directed[i].bx, directed[i].st, a.bx, a.st);
          n_errors++;
        end
      end
      send(directed[i], 1);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 2);
      t = row(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              rnd_coord(mode));
      // mostly the usual beachline picture: both sites above the sweep line
      if ($urandom_range(0, 9) < 6) begin
        t.s = rnd_coord(2) - 32'sh0000_1000;
        if (t.y1 <= t.s) t.y1 = t.s + $urandom_range(1, 1000);
        if (t.y2 <= t.s) t.y2 = t.s + $urandom_range(1, 1000);
      end
      case ($urandom_range(0, 19))
        0: t.y2 = t.y1;
        1: t.s = t.y1;
        2: t.s = t.y2;
        default: ;
      endcase
      send(t, n < N_RANDOM - QUIET_TAIL);
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("checked %0d results over %0d queries", n_checked,
             directed.size() + N_RANDOM);
    $display("status mix: ok %0d, on sweep %0d, equal %0d, no meet %0d, saturated %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pbx_pkg.sv
rtl/pbx_sqrt_pipe.sv
rtl/pbx_div_pipe.sv
rtl/parabola_breakpoint_x_core.sv
verif/tb.sv
